/* sv/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg: buddy page allocator shared definitions
// sizes, payload types, status codes, sequencer states and helpers
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int MAX_ORDER = 12;
    localparam int NUM_ZONES = 4;

    localparam int NUM_LISTS = NUM_ZONES * MAX_ORDER;
    localparam int SLICE     = NUM_PAGES / NUM_ZONES;

    // fixed field widths
    localparam int PAGE_W  = 12;
    localparam int ZONE_W  = 2;
    localparam int FORD_W  = 4;

    // derived internal widths
    localparam int PAGE_AW = $clog2(NUM_PAGES);
    localparam int LINK_W  = $clog2(NUM_PAGES + 1);
    localparam int SUM_W   = LINK_W + 1;
    localparam int OW      = $clog2(MAX_ORDER + 1);
    localparam int LIST_W  = $clog2(NUM_LISTS);
    localparam int STEP_W  = $clog2(NUM_PAGES + 2);

    localparam logic [LINK_W-1:0] NO_PAGE = LINK_W'(NUM_PAGES);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_ORDER = 2'd1,
        STAT_NO_BLOCK  = 2'd2,
        STAT_CORRUPT   = 2'd3
    } status_t;

    typedef struct packed {
        logic              func;
        logic [ZONE_W-1:0] zone;
        logic [FORD_W-1:0] order;
        logic [PAGE_W-1:0] first_page;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_index_out;
        status_t           status;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_INIT_HEADS,
        ST_INIT_BLK,
        ST_INIT_FILL,
        ST_INIT_RDH,
        ST_INIT_PUSH,
        ST_IDLE,
        ST_A_SRD,
        ST_A_SCHK,
        ST_SP_RDN,
        ST_SP_WH,
        ST_SP_SO,
        ST_SP_P1,
        ST_SP_P2,
        ST_A_POPRD,
        ST_A_POPWR,
        ST_CHK,
        ST_MARK,
        ST_A_LINK,
        ST_F_RD,
        ST_F_EVAL,
        ST_F_PUSHRD,
        ST_F_PUSHWR,
        ST_M_TOP,
        ST_M_EVAL,
        ST_UL_RDH,
        ST_UL_HEAD,
        ST_UL_TEST,
        ST_UL_ADV,
        ST_UL_FIX,
        ST_M_SO,
        ST_M_PUSHRD,
        ST_M_PUSHWR
    } state_t;

    function automatic logic [SUM_W-1:0] blk_size(input logic [OW-1:0] o);
        blk_size = SUM_W'(1) << o;
    endfunction

    function automatic logic [LIST_W-1:0] list_addr(input logic [ZONE_W-1:0] z,
                                                    input logic [OW-1:0] o);
        list_addr = LIST_W'(int'(z) * MAX_ORDER + int'(o));
    endfunction

endpackage

`default_nettype wire

/* sv/bpa_if.sv */
// ----------------------------------------------------------------------------
// bpa_if: request and response channels
// valid/ready channels carrying one request or one response item
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_req_if
    import bpa_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bpa_rsp_if
    import bpa_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram: generic single-port-write, registered-read memory
// one write and one read address per cycle, read data held until next read
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/buddy_page_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_page_allocator: zoned buddy allocator over page records
// sequencer walking free lists, splitting and merging blocks one step a cycle
// ----------------------------------------------------------------------------
// The block answers each request with exactly one response item. After reset
// a setup pass builds the free lists before the first request is taken: it
// marks every list head empty, then fills the page records of each initial
// block and pushes that block on its list. A request is then worked through
// by the single sequencer: an allocate searches the orders upward, splits the
// found block down to the asked order, then checks and marks the pages; a
// free checks and clears the pages of its block, and each merge step walks
// its free list and rewrites the order of 2^(o+1) pages. The response sits
// in an output register, so a new request is taken while an earlier response
// still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator
    import bpa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bpa_req_if.sink    req,
    bpa_rsp_if.source  rsp
);

    // sequencer state; the result hand-off is a flag-qualified idle step
    state_t              state_reg,  state_next;
    logic                res_pend_reg, res_pend_next;

    logic                func_reg,   func_next;
    logic [ZONE_W-1:0]   zone_reg,   zone_next;
    logic [OW-1:0]       o_reg,      o_next;
    logic [OW-1:0]       k_reg,      k_next;
    logic [LINK_W-1:0]   blk_reg,    blk_next;
    logic [SUM_W-1:0]    cnt_reg,    cnt_next;
    logic                pend_reg,   pend_next;
    logic [LINK_W-1:0]   cur_reg,    cur_next;
    logic [LINK_W-1:0]   prev_reg,   prev_next;
    logic [STEP_W-1:0]   steps_reg,  steps_next;
    logic [LINK_W-1:0]   pg_reg,     pg_next;
    logic                ul2_reg,    ul2_next;
    logic [SUM_W-1:0]    pos_reg,    pos_next;
    logic [PAGE_W-1:0]   res_page_reg, res_page_next;
    status_t             res_stat_reg, res_stat_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_data_reg,  out_data_next;

    // memory ports
    logic                nx_we, nx_re;
    logic [PAGE_AW-1:0]  nx_wa, nx_ra;
    logic [LINK_W-1:0]   nx_wd, nx_q;
    logic                rec_re;
    logic [PAGE_AW-1:0]  rec_wa, rec_ra;
    logic                ord_we, zn_we, us_we;
    logic [OW-1:0]       ord_wd, ord_q;
    logic [ZONE_W-1:0]   zn_wd, zn_q;
    logic                us_wd, us_q;
    logic                hd_we, hd_re;
    logic [LIST_W-1:0]   hd_wa, hd_ra;
    logic [LINK_W-1:0]   hd_wd, hd_q;

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .re(nx_re), .raddr(nx_ra), .rdata(nx_q)
    );
    bpa_ram #(.WIDTH(OW), .DEPTH(NUM_PAGES)) u_order (
        .clk(clk), .we(ord_we), .waddr(rec_wa), .wdata(ord_wd),
        .re(rec_re), .raddr(rec_ra), .rdata(ord_q)
    );
    bpa_ram #(.WIDTH(ZONE_W), .DEPTH(NUM_PAGES)) u_zone (
        .clk(clk), .we(zn_we), .waddr(rec_wa), .wdata(zn_wd),
        .re(rec_re), .raddr(rec_ra), .rdata(zn_q)
    );
    bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_used (
        .clk(clk), .we(us_we), .waddr(rec_wa), .wdata(us_wd),
        .re(rec_re), .raddr(rec_ra), .rdata(us_q)
    );
    bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_LISTS)) u_heads (
        .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
        .re(hd_re), .raddr(hd_ra), .rdata(hd_q)
    );

    // end of the initial slice of a zone; the last zone takes the remainder
    function automatic logic [SUM_W-1:0] zone_end(input logic [ZONE_W-1:0] z);
        if (int'(z) == NUM_ZONES - 1)
        begin
            zone_end = SUM_W'(NUM_PAGES);
        end
        else
        begin
            zone_end = SUM_W'((int'(z) + 1) * SLICE);
        end
    endfunction

    // ---- shared arithmetic ----
    logic [SUM_W-1:0]  blk_x, sz_o, sz_k, sz_km1, sz_q, bh_x, bud_x, low_x;
    logic [SUM_W-1:0]  pos_end, pos_adv, chk_addr;
    logic [OW-1:0]     init_ord;
    logic              in_acc, out_load;
    logic              chk_rd, chk_fail, f_bad, bud_bad, m_nomatch;
    logic              ul_fail, ul_hit, m_stop, bh_in;

    assign blk_x    = SUM_W'(blk_reg);
    assign sz_o     = blk_size(o_reg);
    assign sz_k     = blk_size(k_reg);
    assign sz_km1   = blk_size(OW'(k_reg - 1'b1));
    assign sz_q     = blk_size(ord_q);
    assign bh_x     = blk_x + sz_km1;
    assign bh_in    = bh_x < SUM_W'(NUM_PAGES);
    assign bud_x    = blk_x ^ sz_o;
    assign low_x    = blk_x & ~sz_o;
    assign pos_end  = zone_end(zone_reg);
    assign pos_adv  = pos_reg + sz_o;
    assign chk_addr = blk_x + cnt_reg;

    assign in_acc   = req.valid && req.ready;
    assign out_load = res_pend_reg && (!out_valid_reg || rsp.ready);

    assign chk_rd   = cnt_reg < sz_o;
    // alloc wants free pages of its order; free wants used pages of one block
    assign chk_fail = (func_reg == FUNC_FREE)
                    ? (ord_q != o_reg || zn_q != zone_reg || !us_q)
                    : (us_q || ord_q != o_reg);
    assign f_bad    = (int'(ord_q) >= MAX_ORDER) || (int'(zn_q) >= NUM_ZONES)
                   || ((blk_x & (sz_q - 1'b1)) != '0)
                   || (blk_x + sz_q > SUM_W'(NUM_PAGES));
    assign m_stop   = (int'(o_reg) + 1 >= MAX_ORDER);
    assign bud_bad  = (bud_x >= SUM_W'(NUM_PAGES)) || (bud_x + sz_o > SUM_W'(NUM_PAGES));
    assign m_nomatch = us_q || ord_q != o_reg || zn_q != zone_reg;
    assign ul_fail  = (cur_reg >= NO_PAGE) || (int'(steps_reg) > NUM_PAGES);
    assign ul_hit   = cur_reg == pg_reg;

    // largest self-aligned block at pos that still fits in the slice
    always_comb
    begin
        init_ord = '0;
        for (int i = 1; i < MAX_ORDER; i++)
        begin
            if (((pos_reg & (blk_size(OW'(i)) - 1'b1)) == '0) &&
                (pos_reg + blk_size(OW'(i)) <= pos_end))
            begin
                init_ord = OW'(i);
            end
        end
    end

    assign req.ready = (state_reg == ST_IDLE) && !res_pend_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT_HEADS: if (int'(cnt_reg) == NUM_LISTS - 1) state_next = ST_INIT_BLK;
            ST_INIT_BLK:   state_next = ST_INIT_FILL;
            ST_INIT_FILL:  if (cnt_reg == sz_o - 1'b1) state_next = ST_INIT_RDH;
            ST_INIT_RDH:   state_next = ST_INIT_PUSH;
            ST_INIT_PUSH:
            begin
                if (pos_adv >= pos_end && int'(zone_reg) == NUM_ZONES - 1)
                    state_next = ST_IDLE;
                else
                    state_next = ST_INIT_BLK;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (req.data.func == FUNC_FREE)
                        state_next = (int'(req.data.first_page) >= NUM_PAGES)
                                   ? ST_IDLE : ST_F_RD;
                    else if (int'(req.data.order) >= MAX_ORDER ||
                             int'(req.data.zone) >= NUM_ZONES)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_A_SRD;
                end
            end
            ST_A_SRD:  state_next = ST_A_SCHK;
            ST_A_SCHK:
            begin
                priority if (hd_q >= NO_PAGE)
                    state_next = (int'(k_reg) + 1 >= MAX_ORDER) ? ST_IDLE : ST_A_SRD;
                else if (k_reg > o_reg)
                    state_next = ST_SP_RDN;
                else
                    state_next = ST_A_POPRD;
            end
            ST_SP_RDN: state_next = ST_SP_WH;
            ST_SP_WH:  state_next = ST_SP_SO;
            ST_SP_SO:  if (cnt_reg == sz_k - 1'b1) state_next = ST_SP_P1;
            ST_SP_P1:  state_next = ST_SP_P2;
            ST_SP_P2:  state_next = (OW'(k_reg - 1'b1) > o_reg) ? ST_SP_RDN : ST_A_POPRD;
            ST_A_POPRD: state_next = ST_A_POPWR;
            ST_A_POPWR:
                state_next = (blk_x + sz_o > SUM_W'(NUM_PAGES)) ? ST_IDLE : ST_CHK;
            ST_CHK:
            begin
                priority if (pend_reg && chk_fail)
                    state_next = ST_IDLE;
                else if (!chk_rd && !pend_reg)
                    state_next = ST_MARK;
            end
            ST_MARK:
            begin
                if (cnt_reg == sz_o - 1'b1)
                    state_next = (func_reg == FUNC_FREE) ? ST_F_PUSHRD : ST_A_LINK;
            end
            ST_A_LINK:   state_next = ST_IDLE;
            ST_F_RD:     state_next = ST_F_EVAL;
            ST_F_EVAL:   state_next = f_bad ? ST_IDLE : ST_CHK;
            ST_F_PUSHRD: state_next = ST_F_PUSHWR;
            ST_F_PUSHWR: state_next = ST_M_TOP;
            ST_M_TOP:    state_next = (m_stop || bud_bad) ? ST_IDLE : ST_M_EVAL;
            ST_M_EVAL:   state_next = m_nomatch ? ST_IDLE : ST_UL_RDH;
            ST_UL_RDH:   state_next = ST_UL_HEAD;
            ST_UL_HEAD:  state_next = ST_UL_TEST;
            ST_UL_TEST:
            begin
                priority if (ul_fail)
                    state_next = ul2_reg ? ST_M_SO : ST_IDLE;
                else if (ul_hit)
                    state_next = ST_UL_FIX;
                else
                    state_next = ST_UL_ADV;
            end
            ST_UL_ADV:   state_next = ST_UL_TEST;
            ST_UL_FIX:   state_next = ul2_reg ? ST_M_SO : ST_UL_RDH;
            ST_M_SO:     if (cnt_reg == (sz_o << 1) - 1'b1) state_next = ST_M_PUSHRD;
            ST_M_PUSHRD: state_next = ST_M_PUSHWR;
            ST_M_PUSHWR: state_next = ST_M_TOP;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---- datapath and memory controls ----
    always_comb
    begin
        func_next     = func_reg;
        zone_next     = zone_reg;
        o_next        = o_reg;
        k_next        = k_reg;
        blk_next      = blk_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        pg_next       = pg_reg;
        ul2_next      = ul2_reg;
        pos_next      = pos_reg;
        res_page_next = res_page_reg;
        res_stat_next = res_stat_reg;
        res_pend_next = res_pend_reg;

        nx_we  = 1'b0;  nx_wa = '0;  nx_wd = '0;  nx_re = 1'b0;  nx_ra = '0;
        rec_re = 1'b0;  rec_wa = '0; rec_ra = '0;
        ord_we = 1'b0;  ord_wd = '0; zn_we = 1'b0; zn_wd = '0;
        us_we  = 1'b0;  us_wd = 1'b0;
        hd_we  = 1'b0;  hd_wa = '0;  hd_wd = '0;  hd_re = 1'b0;  hd_ra = '0;

        if (out_load)
        begin
            res_pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT_HEADS:
            begin
                hd_we = 1'b1;
                hd_wa = LIST_W'(cnt_reg);
                hd_wd = NO_PAGE;
                cnt_next = cnt_reg + 1'b1;
                if (int'(cnt_reg) == NUM_LISTS - 1)
                begin
                    pos_next  = '0;
                    zone_next = '0;
                end
            end
            ST_INIT_BLK:
            begin
                o_next   = init_ord;
                cnt_next = '0;
            end
            ST_INIT_FILL:
            begin
                rec_wa = PAGE_AW'(pos_reg + cnt_reg);
                nx_we  = 1'b1;  nx_wa = rec_wa;  nx_wd = NO_PAGE;
                ord_we = 1'b1;  ord_wd = o_reg;
                zn_we  = 1'b1;  zn_wd = zone_reg;
                us_we  = 1'b1;  us_wd = 1'b0;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_INIT_RDH:
            begin
                hd_re = 1'b1;
                hd_ra = list_addr(zone_reg, o_reg);
            end
            ST_INIT_PUSH:
            begin
                nx_we = 1'b1;  nx_wa = PAGE_AW'(pos_reg);  nx_wd = hd_q;
                hd_we = 1'b1;  hd_wa = list_addr(zone_reg, o_reg);
                hd_wd = LINK_W'(pos_reg);
                pos_next = pos_adv;
                if (pos_adv >= pos_end && int'(zone_reg) != NUM_ZONES - 1)
                begin
                    zone_next = zone_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    func_next = req.data.func;
                    zone_next = req.data.zone;
                    o_next    = OW'(req.data.order);
                    k_next    = OW'(req.data.order);
                    blk_next  = LINK_W'(req.data.first_page);
                    res_page_next = '0;
                    priority if (req.data.func == FUNC_FREE)
                    begin
                        if (int'(req.data.first_page) >= NUM_PAGES)
                        begin
                            res_stat_next = STAT_CORRUPT;
                            res_pend_next = 1'b1;
                        end
                    end
                    else if (int'(req.data.order) >= MAX_ORDER)
                    begin
                        res_stat_next = STAT_BAD_ORDER;
                        res_pend_next = 1'b1;
                    end
                    else if (int'(req.data.zone) >= NUM_ZONES)
                    begin
                        res_stat_next = STAT_NO_BLOCK;
                        res_pend_next = 1'b1;
                    end
                end
            end
            ST_A_SRD:
            begin
                hd_re = 1'b1;
                hd_ra = list_addr(zone_reg, k_reg);
            end
            ST_A_SCHK:
            begin
                if (hd_q >= NO_PAGE)
                begin
                    k_next = k_reg + 1'b1;
                    if (int'(k_reg) + 1 >= MAX_ORDER)
                    begin
                        res_stat_next = STAT_NO_BLOCK;
                        res_pend_next = 1'b1;
                    end
                end
                else
                begin
                    blk_next = hd_q;
                end
            end
            ST_SP_RDN:
            begin
                nx_re = 1'b1;
                nx_ra = PAGE_AW'(blk_reg);
            end
            ST_SP_WH:
            begin
                // pop the block being split, fetch the lower list head
                hd_we = 1'b1;  hd_wa = list_addr(zone_reg, k_reg);  hd_wd = nx_q;
                hd_re = 1'b1;  hd_ra = list_addr(zone_reg, OW'(k_reg - 1'b1));
                cnt_next = '0;
            end
            ST_SP_SO:
            begin
                rec_wa = PAGE_AW'(chk_addr);
                ord_we = chk_addr < SUM_W'(NUM_PAGES);
                ord_wd = OW'(k_reg - 1'b1);
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SP_P1:
            begin
                // upper half goes on first
                nx_we = bh_in;  nx_wa = PAGE_AW'(bh_x);  nx_wd = hd_q;
            end
            ST_SP_P2:
            begin
                nx_we = 1'b1;  nx_wa = PAGE_AW'(blk_reg);
                nx_wd = bh_in ? LINK_W'(bh_x) : hd_q;
                hd_we = 1'b1;  hd_wa = list_addr(zone_reg, OW'(k_reg - 1'b1));
                hd_wd = blk_reg;
                k_next = k_reg - 1'b1;
            end
            ST_A_POPRD:
            begin
                nx_re = 1'b1;
                nx_ra = PAGE_AW'(blk_reg);
            end
            ST_A_POPWR:
            begin
                hd_we = 1'b1;  hd_wa = list_addr(zone_reg, o_reg);  hd_wd = nx_q;
                cnt_next  = '0;
                pend_next = 1'b0;
                if (blk_x + sz_o > SUM_W'(NUM_PAGES))
                begin
                    res_stat_next = STAT_CORRUPT;
                    res_pend_next = 1'b1;
                end
            end
            ST_CHK:
            begin
                // one record read per cycle, checked the cycle after
                rec_re = chk_rd;
                rec_ra = PAGE_AW'(chk_addr);
                pend_next = chk_rd;
                if (chk_rd)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                priority if (pend_reg && chk_fail)
                begin
                    res_page_next = '0;
                    res_stat_next = STAT_CORRUPT;
                    res_pend_next = 1'b1;
                end
                else if (!chk_rd && !pend_reg)
                begin
                    cnt_next = '0;
                end
            end
            ST_MARK:
            begin
                rec_wa = PAGE_AW'(chk_addr);
                us_we  = 1'b1;
                us_wd  = (func_reg == FUNC_ALLOC);
                cnt_next = cnt_reg + 1'b1;
            end
            ST_A_LINK:
            begin
                nx_we = 1'b1;  nx_wa = PAGE_AW'(blk_reg);  nx_wd = NO_PAGE;
                res_page_next = PAGE_W'(blk_reg);
                res_stat_next = STAT_OK;
                res_pend_next = 1'b1;
            end
            ST_F_RD:
            begin
                rec_re = 1'b1;
                rec_ra = PAGE_AW'(blk_reg);
            end
            ST_F_EVAL:
            begin
                o_next    = ord_q;
                zone_next = zn_q;
                cnt_next  = '0;
                pend_next = 1'b0;
                if (f_bad)
                begin
                    res_stat_next = STAT_CORRUPT;
                    res_pend_next = 1'b1;
                end
            end
            ST_F_PUSHRD:
            begin
                hd_re = 1'b1;
                hd_ra = list_addr(zone_reg, o_reg);
            end
            ST_F_PUSHWR:
            begin
                nx_we = 1'b1;  nx_wa = PAGE_AW'(blk_reg);  nx_wd = hd_q;
                hd_we = 1'b1;  hd_wa = list_addr(zone_reg, o_reg);  hd_wd = blk_reg;
            end
            ST_M_TOP:
            begin
                rec_re = 1'b1;
                rec_ra = PAGE_AW'(bud_x);
                pg_next  = LINK_W'(bud_x);
                ul2_next = 1'b0;
                if (m_stop || bud_bad)
                begin
                    res_stat_next = STAT_OK;
                    res_pend_next = 1'b1;
                end
            end
            ST_M_EVAL:
            begin
                if (m_nomatch)
                begin
                    res_stat_next = STAT_OK;
                    res_pend_next = 1'b1;
                end
            end
            ST_UL_RDH:
            begin
                hd_re = 1'b1;
                hd_ra = list_addr(zone_reg, o_reg);
            end
            ST_UL_HEAD:
            begin
                cur_next   = hd_q;
                prev_next  = NO_PAGE;
                steps_next = '0;
            end
            ST_UL_TEST:
            begin
                nx_re = 1'b1;
                nx_ra = PAGE_AW'(cur_reg);
                if (ul_fail)
                begin
                    cnt_next = '0;
                    if (!ul2_reg)
                    begin
                        res_stat_next = STAT_OK;
                        res_pend_next = 1'b1;
                    end
                end
            end
            ST_UL_ADV:
            begin
                prev_next  = cur_reg;
                cur_next   = nx_q;
                steps_next = steps_reg + 1'b1;
            end
            ST_UL_FIX:
            begin
                if (prev_reg == NO_PAGE)
                begin
                    hd_we = 1'b1;  hd_wa = list_addr(zone_reg, o_reg);  hd_wd = nx_q;
                end
                else
                begin
                    nx_we = 1'b1;  nx_wa = PAGE_AW'(prev_reg);  nx_wd = nx_q;
                end
                // buddy gone, now take the block itself off the list
                ul2_next = 1'b1;
                pg_next  = blk_reg;
                cnt_next = '0;
            end
            ST_M_SO:
            begin
                rec_wa = PAGE_AW'(low_x + cnt_reg);
                ord_we = (low_x + cnt_reg) < SUM_W'(NUM_PAGES);
                ord_wd = OW'(o_reg + 1'b1);
                cnt_next = cnt_reg + 1'b1;
            end
            ST_M_PUSHRD:
            begin
                hd_re = 1'b1;
                hd_ra = list_addr(zone_reg, OW'(o_reg + 1'b1));
            end
            ST_M_PUSHWR:
            begin
                nx_we = 1'b1;  nx_wa = PAGE_AW'(low_x);  nx_wd = hd_q;
                hd_we = 1'b1;  hd_wa = list_addr(zone_reg, OW'(o_reg + 1'b1));
                hd_wd = LINK_W'(low_x);
                blk_next = LINK_W'(low_x);
                o_next   = o_reg + 1'b1;
            end
            default:
            begin
                res_pend_next = res_pend_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.page_index_out = res_page_reg;
            out_data_next.status         = res_stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT_HEADS;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pos_reg       <= '0;
            zone_reg      <= '0;
            ul2_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_pend_reg  <= res_pend_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            pos_reg       <= pos_next;
            zone_reg      <= zone_next;
            ul2_reg       <= ul2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        o_reg        <= o_next;
        k_reg        <= k_next;
        blk_reg      <= blk_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        pg_reg       <= pg_next;
        res_page_reg <= res_page_next;
        res_stat_reg <= res_stat_next;
        out_data_reg <= out_data_next;
    end

    // ---- checks ----
    a_split_above_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SP_RDN || state_reg == ST_SP_WH || state_reg == ST_SP_SO ||
         state_reg == ST_SP_P1 || state_reg == ST_SP_P2) |-> (k_reg > o_reg))
        else $error("split running at or below the requested order");

    a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_LINK) |->
            (((blk_x & (sz_o - 1'b1)) == '0) && (blk_reg < NO_PAGE)))
        else $error("allocated block not aligned to its size");

    a_free_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_pend_reg && func_reg == FUNC_FREE) |-> (res_page_reg == '0))
        else $error("free answered a nonzero page");

    a_chk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK) |-> (cnt_reg <= sz_o))
        else $error("page check ran past its block");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: buddy page allocator check
// drives allocate and free requests, predicts every response and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import bpa_pkg::*;
;

    localparam int RUN_LIMIT = 40000000;

    logic clk;
    logic rst_n;

    bpa_req_if req ();
    bpa_rsp_if rsp ();

    buddy_page_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // allocator shadow state, kept at the block's widths
    // ------------------------------------------------------------------
    logic [LINK_W-1:0] pg_next  [NUM_PAGES];
    logic [FORD_W-1:0] pg_order [NUM_PAGES];
    logic [ZONE_W-1:0] pg_zone  [NUM_PAGES];
    logic              pg_used  [NUM_PAGES];
    logic [LINK_W-1:0] list_head[NUM_LISTS];

    rsp_t pending_answers[$];   // responses still owed by the block
    int   live_blocks[$];       // first pages of blocks handed out
    int   errors;
    int   cycles;
    int   hold_off;             // cycles the response side must stay stalled
    int   burst_left;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    function automatic void push_head(input int list, input int pg);
        pg_next[pg] = list_head[list];
        list_head[list] = LINK_W'(pg);
    endfunction

    function automatic void retag_order(input int first, input int count, input int o);
        for (int i = 0; i < count && first + i < NUM_PAGES; i++)
            pg_order[first + i] = FORD_W'(o);
    endfunction

    // drop pg from a free list; false when it is not on the list
    function automatic bit unlink_page(input int list, input int pg);
        int cur;
        int prev;
        cur = list_head[list];
        prev = NUM_PAGES;
        for (int steps = 0; steps <= NUM_PAGES && cur < NUM_PAGES; steps++)
        begin
            if (cur == pg)
            begin
                if (prev == NUM_PAGES)
                    list_head[list] = pg_next[cur];
                else
                    pg_next[prev] = pg_next[cur];
                return 1'b1;
            end
            prev = cur;
            cur = pg_next[cur];
        end
        return 1'b0;
    endfunction

    function automatic void coalesce(input int blk, input int o, input int z);
        int sz;
        int bud;
        int low;
        int base;
        while (o + 1 < MAX_ORDER)
        begin
            sz = 1 << o;
            bud = blk ^ sz;
            low = (blk < bud) ? blk : bud;
            base = z * MAX_ORDER;
            if (bud >= NUM_PAGES || bud + sz > NUM_PAGES)
                return;
            if (pg_used[bud] || pg_order[bud] != o || pg_zone[bud] != z)
                return;
            if (!unlink_page(base + o, bud))
                return;
            void'(unlink_page(base + o, blk));
            retag_order(low, sz << 1, o + 1);
            push_head(base + o + 1, low);
            blk = low;
            o++;
        end
    endfunction

    // initial layout: each zone cut into its largest aligned blocks
    function automatic void layout_zones();
        int pos;
        int stop;
        int o;
        for (int i = 0; i < NUM_LISTS; i++)
            list_head[i] = NO_PAGE;
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            pg_next[i] = NO_PAGE;
            pg_order[i] = '0;
            pg_zone[i] = '0;
            pg_used[i] = 1'b0;
        end
        for (int z = 0; z < NUM_ZONES; z++)
        begin
            pos = z * SLICE;
            stop = (z == NUM_ZONES - 1) ? NUM_PAGES : pos + SLICE;
            while (pos < stop)
            begin
                o = MAX_ORDER - 1;
                while (o > 0 && ((pos & ((1 << o) - 1)) != 0 || pos + (1 << o) > stop))
                    o--;
                for (int i = 0; i < (1 << o); i++)
                begin
                    pg_order[pos + i] = FORD_W'(o);
                    pg_zone[pos + i] = ZONE_W'(z);
                end
                push_head(z * MAX_ORDER + o, pos);
                pos += 1 << o;
            end
        end
    endfunction

    function automatic rsp_t answer(input int pg, input status_t st);
        rsp_t r;
        r.page_index_out = PAGE_W'(pg);
        r.status = st;
        return r;
    endfunction

    function automatic rsp_t alloc_block(input int z, input int o);
        int base;
        int k;
        int b;
        int half;
        int idx;
        if (o >= MAX_ORDER)
            return answer(0, STAT_BAD_ORDER);
        if (z >= NUM_ZONES)
            return answer(0, STAT_NO_BLOCK);
        base = z * MAX_ORDER;
        k = o;
        while (k < MAX_ORDER && list_head[base + k] >= NUM_PAGES)
            k++;
        if (k >= MAX_ORDER)
            return answer(0, STAT_NO_BLOCK);
        // split the found block down to the asked order
        while (k > o)
        begin
            b = list_head[base + k];
            half = 1 << (k - 1);
            list_head[base + k] = pg_next[b];
            retag_order(b, half << 1, k - 1);
            if (b + half < NUM_PAGES)
                push_head(base + k - 1, b + half);
            push_head(base + k - 1, b);
            k--;
        end
        idx = list_head[base + o];
        if (idx >= NUM_PAGES)
            return answer(0, STAT_NO_BLOCK);
        list_head[base + o] = pg_next[idx];
        if (idx + (1 << o) > NUM_PAGES)
            return answer(0, STAT_CORRUPT);
        for (int i = 0; i < (1 << o); i++)
            if (pg_used[idx + i] || pg_order[idx + i] != o)
                return answer(0, STAT_CORRUPT);
        for (int i = 0; i < (1 << o); i++)
            pg_used[idx + i] = 1'b1;
        pg_next[idx] = NO_PAGE;
        return answer(idx, STAT_OK);
    endfunction

    function automatic rsp_t free_block(input int idx);
        int o;
        int z;
        int sz;
        if (idx >= NUM_PAGES)
            return answer(0, STAT_CORRUPT);
        o = pg_order[idx];
        z = pg_zone[idx];
        if (o >= MAX_ORDER || z >= NUM_ZONES)
            return answer(0, STAT_CORRUPT);
        sz = 1 << o;
        if ((idx & (sz - 1)) != 0 || idx + sz > NUM_PAGES)
            return answer(0, STAT_CORRUPT);
        for (int i = 0; i < sz; i++)
            if (pg_order[idx + i] != o || pg_zone[idx + i] != z || !pg_used[idx + i])
                return answer(0, STAT_CORRUPT);
        for (int i = 0; i < sz; i++)
            pg_used[idx + i] = 1'b0;
        push_head(z * MAX_ORDER + o, idx);
        coalesce(idx, o, z);
        return answer(0, STAT_OK);
    endfunction

    // ------------------------------------------------------------------
    // request side: one item per call, bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send_request(input req_t item);
        rsp_t r;
        int gap;
        req.valid <= 1'b1;
        req.data <= item;
        do
            @(posedge clk);
        while (!req.ready);
        // accepted at this edge: predict and keep the live block list in step
        if (item.func == FUNC_ALLOC)
        begin
            r = alloc_block(item.zone, item.order);
            if (r.status == STAT_OK)
                live_blocks.push_back(r.page_index_out);
        end
        else
        begin
            r = free_block(item.first_page);
            if (r.status == STAT_OK)
                foreach (live_blocks[i])
                    if (live_blocks[i] == item.first_page)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
        end
        pending_answers.push_back(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_alloc(input int z, input int o);
        req_t item;
        item = '0;
        item.func = FUNC_ALLOC;
        item.zone = ZONE_W'(z);
        item.order = FORD_W'(o);
        item.first_page = PAGE_W'($urandom);
        send_request(item);
    endtask

    task automatic send_free(input int pg);
        req_t item;
        item.func = FUNC_FREE;
        item.zone = ZONE_W'($urandom);
        item.order = FORD_W'($urandom);
        item.first_page = PAGE_W'(pg);
        send_request(item);
    endtask

    // sender stops until every owed response is back
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // response side: check each item, stall on its own pattern
    // ------------------------------------------------------------------
    int stall_phase;

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected response, page", rsp.data.page_index_out, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.data.page_index_out !== want.page_index_out)
                    report_mismatch("page_index_out", rsp.data.page_index_out,
                                    want.page_index_out);
                if (rsp.data.status !== want.status)
                    report_mismatch("status", rsp.data.status, want.status);
            end
        end
        // stretches of full speed alternate with random stalls
        if (stall_phase == 0)
            stall_phase = $urandom_range(1, 120);
        else
            stall_phase--;
        if (hold_off > 0)
        begin
            hold_off--;
            rsp.ready <= 1'b0;
        end
        else if (stall_phase > 60)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 2) != 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("buddy_page_allocator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // each zone starts as one order 10 block; take it, find it gone, return it
    task automatic test_initial_blocks();
        for (int z = 0; z < NUM_ZONES; z++)
            send_alloc(z, 10);
        send_alloc(3, 10);
        send_alloc(0, 0);
        for (int z = 0; z < NUM_ZONES; z++)
            send_free(z * SLICE);
        drain();
    endtask

    // order 11 cannot exist in a slice, 12 and up are rejected
    task automatic test_order_range();
        send_alloc(1, 11);
        send_alloc(2, 12);
        send_alloc(0, 15);
        send_alloc(3, 0);
        send_free(live_blocks[live_blocks.size() - 1]);
    endtask

    // small blocks split from the top and merge all the way back
    task automatic test_split_merge();
        send_alloc(2, 0);
        send_alloc(2, 0);
        send_alloc(2, 3);
        send_free(2 * SLICE);
        send_free(2 * SLICE);       // double free
        send_free(2 * SLICE + 1);
        send_free(2 * SLICE + 8);
        send_free(4095);            // never allocated
        send_free(2 * SLICE + 3);   // not block aligned
        drain();
    endtask

    task automatic test_random(input int n);
        int pick;
        int o;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (live_blocks.size() > 40)
                pick = pick / 2 + 50;
            if (pick < 52)
            begin
                // mostly small orders, a few large or out of range ones
                o = $urandom_range(0, 99);
                if (o < 75)
                    o = $urandom_range(0, 3);
                else if (o < 93)
                    o = $urandom_range(4, 7);
                else
                    o = $urandom_range(8, 15);
                send_alloc($urandom_range(0, 3), o);
            end
            else if (pick < 90 && live_blocks.size() != 0)
                send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            else
                send_free($urandom_range(0, NUM_PAGES - 1));
        end
    endtask

    // stall responses for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_off = 500;
        test_random(24);
        drain();
    endtask

    task automatic release_all();
        while (live_blocks.size() != 0)
            send_free(live_blocks[0]);
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        burst_left = 0;
        stall_phase = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        layout_zones();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_initial_blocks();
        test_order_range();
        test_split_merge();
        test_random(420);
        test_backpressure();
        test_random(420);
        release_all();

        repeat (300) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("buddy_page_allocator verification clean");
        else
            $display("buddy_page_allocator verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/bpa_pkg.sv
sv/bpa_if.sv
sv/bpa_ram.sv
sv/buddy_page_allocator.sv
sim/testbench.sv
